// ===== design/s5scan_pkg.sv =====
// s5scan_pkg: shared types and byte constants for the S5 sleep-type scanner.
// No dependencies; used by s5scan_parser and aml_s5_sleep_type_scanner.
package s5scan_pkg;

   localparam int HEADER_BYTES_DEF = 36;

   localparam logic [7:0] CH_UNDERSCORE  = 8'h5F;
   localparam logic [7:0] CH_S           = 8'h53;
   localparam logic [7:0] CH_FIVE        = 8'h35;
   localparam logic [7:0] CH_BACKSLASH   = 8'h5C;
   localparam logic [7:0] OP_NAME        = 8'h08;
   localparam logic [7:0] OP_PACKAGE     = 8'h12;
   localparam logic [7:0] OP_BYTE_PREFIX = 8'h0A;
   localparam logic [7:0] LEAD_SIZE_MASK = 8'hC0;
   localparam logic [7:0] TYPE_MASK      = 8'h07;

   localparam int WINDOW_DEPTH = 6;
   localparam int SKIP_W       = 2;
   localparam int TYPE_W       = 3;

   typedef enum logic [8:0] {
      PH_SEARCH  = 9'b000000001,
      PH_LEAD    = 9'b000000010,
      PH_PKGSKIP = 9'b000000100,
      PH_COUNT   = 9'b000001000,
      PH_ELEM_A  = 9'b000010000,
      PH_VAL_A   = 9'b000100000,
      PH_ELEM_B  = 9'b001000000,
      PH_VAL_B   = 9'b010000000,
      PH_DONE    = 9'b100000000
   } phase_type;

   // one byte handed from the input register to the parser
   typedef struct packed {
      logic       go;
      logic       last;
      logic [7:0] data;
   } step_type;

   // per-table result
   typedef struct packed {
      logic              found;
      logic [TYPE_W-1:0] type_a;
      logic [TYPE_W-1:0] type_b;
   } result_type;

endpackage

// ===== design/s5scan_parser.sv =====
// s5scan_parser: byte window, position counter and package phase tracker.
// Depends on s5scan_pkg. Produces the table result for the byte being stepped.
module s5scan_parser #(
   parameter int HEADER_BYTES = s5scan_pkg::HEADER_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  s5scan_pkg::step_type    step,
   output s5scan_pkg::result_type  result
);

   localparam int POS_W = $clog2(HEADER_BYTES + 5);
   localparam logic [POS_W-1:0] POS_SAT = POS_W'(HEADER_BYTES + 4);
   localparam int TW = s5scan_pkg::TYPE_W;
   localparam int SW = s5scan_pkg::SKIP_W;

   logic [7:0]             recent_ff [s5scan_pkg::WINDOW_DEPTH];
   logic [POS_W-1:0]       pos_ff, pos_in;
   s5scan_pkg::phase_type  phase_ff, phase_in;
   logic [SW-1:0]          skip_ff, skip_in;
   logic [TW-1:0]          type_a_ff, type_a_in;
   logic [TW-1:0]          type_b_ff, type_b_in;
   logic                   hit_ff, hit_in;
   logic                   name_ok;
   logic                   window_hit;
   logic [7:0]             lead_bits;

   assign name_ok = (recent_ff[4] == s5scan_pkg::OP_NAME) ||
                    (recent_ff[5] == s5scan_pkg::OP_NAME &&
                     recent_ff[4] == s5scan_pkg::CH_BACKSLASH);

   assign window_hit = (step.data == s5scan_pkg::OP_PACKAGE) && (pos_ff >= POS_SAT) &&
                       (recent_ff[0] == s5scan_pkg::CH_UNDERSCORE) &&
                       (recent_ff[1] == s5scan_pkg::CH_FIVE) &&
                       (recent_ff[2] == s5scan_pkg::CH_S) &&
                       (recent_ff[3] == s5scan_pkg::CH_UNDERSCORE) && name_ok;

   assign lead_bits = step.data & s5scan_pkg::LEAD_SIZE_MASK;

   always_comb begin
      phase_in  = phase_ff;
      skip_in   = skip_ff;
      type_a_in = type_a_ff;
      type_b_in = type_b_ff;
      hit_in    = hit_ff;
      pos_in    = (pos_ff < POS_SAT) ? pos_ff + 1'b1 : pos_ff;
      unique case (phase_ff)
         s5scan_pkg::PH_SEARCH: begin
            if (window_hit) phase_in = s5scan_pkg::PH_LEAD;
         end
         s5scan_pkg::PH_LEAD: begin
            skip_in  = lead_bits[7:6];
            phase_in = (lead_bits[7:6] != '0) ? s5scan_pkg::PH_PKGSKIP
                                              : s5scan_pkg::PH_COUNT;
         end
         s5scan_pkg::PH_PKGSKIP: begin
            skip_in = skip_ff - 1'b1;
            if (skip_ff == SW'(1)) phase_in = s5scan_pkg::PH_COUNT;
         end
         s5scan_pkg::PH_COUNT: begin
            phase_in = s5scan_pkg::PH_ELEM_A;
         end
         s5scan_pkg::PH_ELEM_A: begin
            if (step.data == s5scan_pkg::OP_BYTE_PREFIX) begin
               phase_in = s5scan_pkg::PH_VAL_A;
            end else begin
               type_a_in = step.data[TW-1:0];
               hit_in    = 1'b1;
               phase_in  = s5scan_pkg::PH_ELEM_B;
            end
         end
         s5scan_pkg::PH_VAL_A: begin
            type_a_in = step.data[TW-1:0];
            hit_in    = 1'b1;
            phase_in  = s5scan_pkg::PH_ELEM_B;
         end
         s5scan_pkg::PH_ELEM_B: begin
            if (step.data == s5scan_pkg::OP_BYTE_PREFIX) begin
               phase_in = s5scan_pkg::PH_VAL_B;
            end else begin
               type_b_in = step.data[TW-1:0];
               phase_in  = s5scan_pkg::PH_DONE;
            end
         end
         s5scan_pkg::PH_VAL_B: begin
            type_b_in = step.data[TW-1:0];
            phase_in  = s5scan_pkg::PH_DONE;
         end
         s5scan_pkg::PH_DONE: begin
            phase_in = s5scan_pkg::PH_DONE;
         end
         default: begin
            phase_in = s5scan_pkg::PH_SEARCH;
         end
      endcase
   end

   // result as seen after this byte; type values are only ever set after a hit
   assign result.found  = hit_in;
   assign result.type_a = type_a_in;
   assign result.type_b = type_b_in;

   always_ff @(posedge clock) begin
      if (reset || (step.go && step.last)) begin
         for (int i = 0; i < s5scan_pkg::WINDOW_DEPTH; i++) recent_ff[i] <= '0;
         pos_ff    <= '0;
         phase_ff  <= s5scan_pkg::PH_SEARCH;
         skip_ff   <= '0;
         type_a_ff <= '0;
         type_b_ff <= '0;
         hit_ff    <= 1'b0;
      end else if (step.go) begin
         recent_ff[0] <= step.data;
         for (int i = 1; i < s5scan_pkg::WINDOW_DEPTH; i++) recent_ff[i] <= recent_ff[i-1];
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         skip_ff   <= skip_in;
         type_a_ff <= type_a_in;
         type_b_ff <= type_b_in;
         hit_ff    <= hit_in;
      end
   end

endmodule

// ===== design/aml_s5_sleep_type_scanner.sv =====
// aml_s5_sleep_type_scanner: top level with input word register and result register.
// Depends on s5scan_pkg and s5scan_parser.
//
// Scans one description table per frame, one byte word per cycle, and returns one
// result word at the table's last byte: found flag and the two S5 sleep types.
// Each byte steps the parser once; a word passes the input register and
// the result register, so a result is registered after the last byte leaves the input register.
// Throughput is one byte per cycle; the input stalls only when a finished result
// is still waiting on rsp_tready and the next last byte needs the result register.
module aml_s5_sleep_type_scanner #(
   parameter int HEADER_BYTES = s5scan_pkg::HEADER_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // table_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] found, [3:1] sleep_type_a, [6:4] sleep_type_b, [7] zero
);

   logic                    in_vld_ff, in_vld_in;
   logic [7:0]              in_data_ff;
   logic                    in_last_ff;
   logic                    rsp_vld_ff, rsp_vld_in;
   s5scan_pkg::result_type  rsp_ff;
   s5scan_pkg::result_type  result;
   s5scan_pkg::step_type    step;
   logic                    advance;
   logic                    req_take;

   assign advance  = in_vld_ff && (!in_last_ff || !rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_take = req_tvalid && req_tready;

   assign in_vld_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign rsp_vld_in = (advance && in_last_ff) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   assign step.go   = advance;
   assign step.last = in_last_ff;
   assign step.data = in_data_ff;

   s5scan_parser #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) rsp_ff <= result;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.type_b, rsp_ff.type_a, rsp_ff.found};

endmodule

// ===== design/s5scan_checker.sv =====
// s5scan_checker: port-level checks on the S5 scanner result channel.
// Depends on aml_s5_sleep_type_scanner's ports; attached by bind below.
module s5scan_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[6:1] == 6'd0)
      else $error("sleep types nonzero without a hit");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7])
      else $error("pad bit set in result word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind aml_s5_sleep_type_scanner s5scan_checker u_s5scan_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/s5_result_checker.sv =====
`timescale 1ns / 100ps
// s5_result_checker: watches both stream channels of the S5 sleep-type scanner, predicts
// each table's result word and compares it. Depends on s5scan_pkg.
module s5_result_checker #(
   parameter int HEADER_BYTES = s5scan_pkg::HEADER_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   output int         errors,
   output int         results_due,
   output int         tables_done,
   output int         hits_done
);
   import s5scan_pkg::*;

   localparam logic [6:0] NAME_FLOOR = 7'(HEADER_BYTES + 4);

   logic [7:0] tail_bytes [6];
   logic [6:0] byte_index;
   phase_type  scan_phase;
   logic [1:0] len_skip;
   logic [2:0] slp_a, slp_b;
   logic       got_a;

   result_type sleep_types_due [$];
   int fails = 0;
   int tables_seen = 0;
   int founds = 0;

   task automatic clear_scan();
      for (int i = 0; i < 6; i++) tail_bytes[i] = 8'h00;
      byte_index = '0;
      scan_phase = PH_SEARCH;
      len_skip = '0;
      slp_a = '0;
      slp_b = '0;
      got_a = 1'b0;
   endtask

   function automatic logic s5_name_ahead(input logic [7:0] b);
      return b == OP_PACKAGE && byte_index >= NAME_FLOOR &&
         tail_bytes[0] == CH_UNDERSCORE && tail_bytes[1] == CH_FIVE &&
         tail_bytes[2] == CH_S && tail_bytes[3] == CH_UNDERSCORE &&
         (tail_bytes[4] == OP_NAME ||
          (tail_bytes[5] == OP_NAME && tail_bytes[4] == CH_BACKSLASH));
   endfunction

   task automatic scan_byte(input logic [7:0] b, input logic last);
      result_type res;
      case (scan_phase)
         PH_SEARCH: begin
            if (s5_name_ahead(b)) scan_phase = PH_LEAD;
         end
         PH_LEAD: begin
            len_skip = b[7:6];
            scan_phase = (len_skip != 2'd0) ? PH_PKGSKIP : PH_COUNT;
         end
         PH_PKGSKIP: begin
            len_skip = len_skip - 2'd1;
            if (len_skip == 2'd0) scan_phase = PH_COUNT;
         end
         PH_COUNT: scan_phase = PH_ELEM_A;
         PH_ELEM_A: begin
            if (b == OP_BYTE_PREFIX) begin
               scan_phase = PH_VAL_A;
            end else begin
               slp_a = b[2:0];
               got_a = 1'b1;
               scan_phase = PH_ELEM_B;
            end
         end
         PH_VAL_A: begin
            slp_a = b[2:0];
            got_a = 1'b1;
            scan_phase = PH_ELEM_B;
         end
         PH_ELEM_B: begin
            if (b == OP_BYTE_PREFIX) begin
               scan_phase = PH_VAL_B;
            end else begin
               slp_b = b[2:0];
               scan_phase = PH_DONE;
            end
         end
         PH_VAL_B: begin
            slp_b = b[2:0];
            scan_phase = PH_DONE;
         end
         default: ;
      endcase
      for (int i = 5; i > 0; i--) tail_bytes[i] = tail_bytes[i-1];
      tail_bytes[0] = b;
      if (byte_index < NAME_FLOOR) byte_index = byte_index + 7'd1;
      if (last) begin
         res.found  = got_a;
         res.type_a = got_a ? slp_a : 3'd0;
         res.type_b = got_a ? slp_b : 3'd0;
         sleep_types_due.push_back(res);
         clear_scan();
      end
   endtask

   always @(posedge clock) begin : watch_words
      result_type want;
      if (reset) begin
         clear_scan();
         sleep_types_due.delete();
      end else begin
         // result side first: a word taken now belongs to an earlier table
         if (rsp_tvalid && rsp_tready) begin
            if (sleep_types_due.size() == 0) begin
               if (fails < 10)
                  $display("%0t: result word %h with no table pending", $time, rsp_tdata);
               fails++;
            end else begin
               want = sleep_types_due.pop_front();
               tables_seen++;
               if (want.found) founds++;
               if (rsp_tdata[0] !== want.found || rsp_tdata[3:1] !== want.type_a ||
                   rsp_tdata[6:4] !== want.type_b || rsp_tdata[7] !== 1'b0) begin
                  if (fails < 10)
                     $display({"%0t: table %0d expected found=%0d a=%0d b=%0d, ",
                               "got found=%0d a=%0d b=%0d pad=%0d"},
                        $time, tables_seen, want.found, want.type_a, want.type_b,
                        rsp_tdata[0], rsp_tdata[3:1], rsp_tdata[6:4], rsp_tdata[7]);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
      end
      errors <= fails;
      results_due <= sleep_types_due.size();
      tables_done <= tables_seen;
      hits_done <= founds;
   end

endmodule

// ===== tb/aml_s5_sleep_type_scanner_tb.sv =====
`timescale 1ns / 100ps
// aml_s5_sleep_type_scanner_tb: feeds description tables byte by byte into the S5
// sleep-type scanner with random stalls; depends on s5scan_pkg and s5_result_checker.
module aml_s5_sleep_type_scanner_tb;
   import s5scan_pkg::*;

   localparam int HDR = HEADER_BYTES_DEF;
   localparam int QUIET_LIMIT = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // table_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b1;
   logic [7:0] rsp_tdata;           // [0] found, [3:1] sleep_type_a, [6:4] sleep_type_b

   int errors, results_due, tables_done, hits_done;

   logic [7:0] table_q [$];
   int  send_gap_pct = 0;
   int  sink_stall_pct = 0;
   int  stall_left = 0;
   int  quiet = 0;
   int  bytes_sent = 0;
   int  tables_sent = 0;
   bit  calm = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   aml_s5_sleep_type_scanner #(.HEADER_BYTES(HDR)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   s5_result_checker #(.HEADER_BYTES(HDR)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .errors(errors), .results_due(results_due),
      .tables_done(tables_done), .hits_done(hits_done)
   );

   // result-side backpressure in bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
         stall_left <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [7:0] rnd_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic add_noise(input int n);
      repeat (n) table_q.push_back(rnd_byte());
   endtask

   task automatic chop(input int n);
      repeat (n) table_q.delete(table_q.size() - 1);
   endtask

   // name op, optional backslash, _S5_, package op, length, count, two elements
   task automatic add_s5(input bit bslash, input logic [1:0] len_sz, input bit pfx_a,
         input logic [7:0] val_a, input bit pfx_b, input logic [7:0] val_b);
      logic [7:0] lead;
      lead = rnd_byte();
      lead[7:6] = len_sz;
      table_q.push_back(OP_NAME);
      if (bslash) table_q.push_back(CH_BACKSLASH);
      table_q.push_back(CH_UNDERSCORE);
      table_q.push_back(CH_S);
      table_q.push_back(CH_FIVE);
      table_q.push_back(CH_UNDERSCORE);
      table_q.push_back(OP_PACKAGE);
      table_q.push_back(lead);
      add_noise(int'(len_sz));
      table_q.push_back(rnd_byte());
      if (pfx_a) table_q.push_back(OP_BYTE_PREFIX);
      table_q.push_back(val_a);
      if (pfx_b) table_q.push_back(OP_BYTE_PREFIX);
      table_q.push_back(val_b);
   endtask

   task automatic add_random_s5(input bit bslash);
      add_s5(bslash, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rnd_byte(),
         1'($urandom_range(0, 1)), rnd_byte());
   endtask

   task automatic random_table();
      int kind, pre, start, r;
      bit bs;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         add_noise($urandom_range(1, 12));
      end else if (kind == 3) begin
         add_noise(HDR + $urandom_range(0, 30));
      end else begin
         bs = 1'($urandom_range(0, 1));
         // kind 9 puts the leading underscore one before, at, or one after the header end
         if (kind == 9) pre = HDR - 2 - int'(bs) + $urandom_range(0, 2);
         else pre = HDR + $urandom_range(0, 8);
         add_noise(pre);
         start = table_q.size();
         add_random_s5(bs);
         r = $urandom_range(0, 99);
         if (r < 15) table_q[start + $urandom_range(0, table_q.size() - start - 1)] = rnd_byte();
         if (r >= 78) begin
            chop($urandom_range(1, table_q.size() - start - 1));
         end else begin
            if ($urandom_range(0, 4) == 0) add_random_s5(1'($urandom_range(0, 1)));
            add_noise($urandom_range(0, 6));
         end
      end
   endtask

   task automatic send_table();
      for (int i = 0; i < table_q.size(); i++) begin
         if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= table_q[i];
         req_tlast <= (i == table_q.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         bytes_sent++;
      end
      table_q.delete();
      tables_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 20;
      sink_stall_pct = 20;

      // one-byte tables
      table_q.push_back(8'h00);
      send_table();
      table_q.push_back(8'hFF);
      send_table();
      // plain hit, no prefixes, one-byte length
      add_noise(HDR);
      add_s5(1'b0, 2'd0, 1'b0, 8'h01, 1'b0, 8'h05);
      send_table();
      // backslash form, longest length, both prefixed, values masked
      add_noise(HDR + 3);
      add_s5(1'b1, 2'd3, 1'b1, 8'hFF, 1'b1, 8'hFE);
      add_noise(4);
      send_table();
      // ends right after the first prefix
      add_noise(HDR);
      add_s5(1'b0, 2'd1, 1'b1, 8'h03, 1'b1, 8'h04);
      chop(3);
      send_table();
      // ends right after the second prefix
      add_noise(HDR);
      add_s5(1'b0, 2'd2, 1'b0, 8'h06, 1'b1, 8'h07);
      chop(1);
      send_table();
      // ends before the second value
      add_noise(HDR);
      add_s5(1'b0, 2'd0, 1'b0, 8'h02, 1'b0, 8'h03);
      chop(1);
      send_table();
      // ends inside the package length
      add_noise(HDR);
      add_s5(1'b0, 2'd3, 1'b0, 8'h02, 1'b0, 8'h03);
      chop(4);
      send_table();
      // name starts one byte inside the header: no hit
      add_noise(HDR - 2);
      add_s5(1'b0, 2'd0, 1'b0, 8'h04, 1'b0, 8'h05);
      add_noise(2);
      send_table();
      // name starts right at the header end: hit
      add_noise(HDR - 1);
      add_s5(1'b0, 2'd0, 1'b0, 8'h04, 1'b0, 8'h05);
      send_table();
      // two packages, the first one wins
      add_noise(HDR);
      add_s5(1'b1, 2'd0, 1'b0, 8'h11, 1'b0, 8'h22);
      add_s5(1'b0, 2'd0, 1'b0, 8'h33, 1'b0, 8'h44);
      send_table();
      // backslash without a name op in front
      add_noise(HDR);
      start = table_q.size();
      add_s5(1'b1, 2'd0, 1'b0, 8'h05, 1'b0, 8'h06);
      table_q[start] = 8'h00;
      send_table();
      wait_drained();

      while (bytes_sent < 1500) begin
         send_gap_pct = 15 * $urandom_range(0, 2);
         sink_stall_pct = 10 * $urandom_range(0, 3);
         if (bytes_sent >= 1250) calm <= 1'b1;
         random_table();
         send_table();
         if ($urandom_range(0, 11) == 0) wait_drained();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("%0d tables in %0d bytes, S5 package read in %0d of them",
         tables_done, bytes_sent, hits_done);
      $display("truncations, header edge, prefixes and backpressure exercised; %0d mismatches",
         errors);
      if (errors == 0 && results_due == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
